// File: rtl/core/ans_pkg.sv
// Package for the adaptive neighborhood support block: widths, item and job structs,
// the back-end state type and the constant tables built at elaboration.
// No dependencies.
package ans_pkg;

  localparam int NBR_CAPACITY_DEF  = 32;
  localparam int CNT_W             = 7;
  localparam int DIST_W            = 32;
  localparam int HALF_W            = DIST_W / 2;
  localparam int DENS_W            = 16;
  localparam int PROD_W            = DENS_W + DIST_W;
  localparam int LIMIT_W           = 37;
  localparam int LIMIT_ENTRIES     = 64;
  localparam int LIMIT_IDX_W       = $clog2(LIMIT_ENTRIES);
  localparam int K_W               = 27;
  localparam int K_ENTRIES         = 65;
  localparam int ROOT_W            = 26;
  localparam int SQ_SRC_W          = 2 * ROOT_W;
  localparam int STEP_W            = $clog2(ROOT_W);
  localparam int SCALE_SH          = 8;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [63:0]        PI_Q24         = 64'd52707179;
  localparam logic [63:0]        HALF_PI_Q24    = 64'd26353589;
  localparam logic [CNT_W-1:0]   MIN_RANGE      = 7'd3;
  localparam logic [CNT_W-1:0]   FIRST_TEST_POS = 7'd2;
  localparam logic [DENS_W-1:0]  DENSITY_RST    = 16'd1311;

  typedef enum logic {
    CFG_DENSITY      = 1'b0,
    CFG_RADIUS_GIVEN = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_SUM,
    BK_ROOT,
    BK_OUT
  } back_state_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              last;
    logic [DIST_W-1:0] given_radius;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]  range;
    logic [DIST_W-1:0] support;
    logic [DIST_W-1:0] radius;
    logic              overflow;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]  range;
    logic [CNT_W-1:0]  n;
    logic [DIST_W-1:0] distance;
    logic [DIST_W-1:0] given_radius;
    logic              overflow;
  } job_t;

  typedef logic [LIMIT_ENTRIES-1:0][LIMIT_W-1:0] limit_tbl_t;
  typedef logic [K_ENTRIES-1:0][K_W-1:0]         k_tbl_t;

  function automatic logic [63:0] isqrt_c(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) begin
        root = trial;
      end
    end
    return root;
  endfunction

  function automatic logic [63:0] udiv_c(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Largest density product p for which index i still passes: p * PI_Q24 < i * 2^56.
  function automatic limit_tbl_t build_limits();
    limit_tbl_t  t;
    logic [63:0] num;
    t = '0;
    for (int i = 1; i < LIMIT_ENTRIES; i++) begin
      num  = (64'(i) << 56) - 64'd1;
      t[i] = LIMIT_W'(num / PI_Q24);
    end
    return t;
  endfunction

  // 4 / (n - sqrt(pi * n) + pi / 2) in Q24 for each neighbor count.
  function automatic k_tbl_t build_k();
    k_tbl_t      t;
    logic [63:0] s;
    logic [63:0] den;
    t = '0;
    for (int n = 0; n < K_ENTRIES; n++) begin
      s    = isqrt_c((PI_Q24 * 64'(n)) << 24);
      den  = (64'(n) << 24) - s + HALF_PI_Q24;
      t[n] = K_W'(udiv_c(64'd1 << 50, den));
    end
    return t;
  endfunction

  localparam limit_tbl_t DENS_LIMIT = build_limits();
  localparam k_tbl_t     K_TABLE    = build_k();

endpackage

// File: rtl/core/ans_front.sv
// Front end: accepts neighbor distances, counts them, runs the density test
// and hands one job per point to the queue. Depends on ans_pkg.
module ans_front
  import ans_pkg::*;
#(
  parameter int NBR_CAPACITY = NBR_CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [DENS_W-1:0] density,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              job_valid,
  input  logic              job_ready,
  output job_t              job_data
);

  localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(NBR_CAPACITY);

  typedef struct packed {
    logic [PROD_W-1:0] product;
    logic [CNT_W-1:0]  idx;
    logic              test_en;
    logic              last;
    logic [CNT_W-1:0]  n;
    logic              overflow;
    logic [DIST_W-1:0] distance;
    logic [DIST_W-1:0] given_radius;
  } stage_t;

  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             too_many_r, too_many_nxt;
  logic             s1_valid_r, s1_valid_nxt;
  stage_t           s1_r, s1_nxt;
  logic             found_r, found_nxt;
  logic [CNT_W-1:0] found_range_r, found_range_nxt;
  logic             accept;
  logic             s1_done;
  logic             room;
  logic             fail;
  logic [CNT_W-1:0] idx_inc;

  assign accept   = in_valid && in_ready;
  assign s1_done  = s1_valid_r && (!s1_r.last || job_ready);
  assign in_ready = !s1_valid_r || s1_done;
  assign room     = idx_r < CAPACITY;
  assign idx_inc  = idx_r + CNT_W'(1);
  assign fail     = s1_r.test_en &&
                    (s1_r.product > PROD_W'(DENS_LIMIT[s1_r.idx[LIMIT_IDX_W-1:0]]));

  always_comb begin
    idx_nxt      = idx_r;
    too_many_nxt = too_many_r;
    s1_valid_nxt = s1_valid_r;
    s1_nxt       = s1_r;
    if (s1_done) begin
      s1_valid_nxt = 1'b0;
    end
    if (accept) begin
      s1_valid_nxt         = 1'b1;
      s1_nxt.product       = PROD_W'(density) * PROD_W'(in_data.distance);
      s1_nxt.idx           = idx_inc;
      s1_nxt.test_en       = room && !in_data.last && (idx_r >= FIRST_TEST_POS) &&
                             (idx_inc < CAPACITY);
      s1_nxt.last          = in_data.last;
      s1_nxt.n             = room ? idx_inc : idx_r;
      s1_nxt.overflow      = too_many_r || !room;
      s1_nxt.distance      = in_data.distance;
      s1_nxt.given_radius  = in_data.given_radius;
      if (in_data.last) begin
        idx_nxt      = '0;
        too_many_nxt = 1'b0;
      end else if (room) begin
        idx_nxt = idx_inc;
      end else begin
        too_many_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    found_nxt       = found_r;
    found_range_nxt = found_range_r;
    if (s1_done) begin
      if (s1_r.last) begin
        found_nxt       = 1'b0;
        found_range_nxt = '0;
      end else if (fail && !found_r) begin
        found_nxt       = 1'b1;
        found_range_nxt = s1_r.idx;
      end
    end
  end

  assign job_valid             = s1_valid_r && s1_r.last;
  assign job_data.range        = found_r ? found_range_r :
                                 ((s1_r.n < MIN_RANGE) ? MIN_RANGE : s1_r.n);
  assign job_data.n            = s1_r.n;
  assign job_data.distance     = s1_r.distance;
  assign job_data.given_radius = s1_r.given_radius;
  assign job_data.overflow     = s1_r.overflow;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r         <= '0;
      too_many_r    <= 1'b0;
      s1_valid_r    <= 1'b0;
      found_r       <= 1'b0;
      found_range_r <= '0;
    end else begin
      idx_r         <= idx_nxt;
      too_many_r    <= too_many_nxt;
      s1_valid_r    <= s1_valid_nxt;
      found_r       <= found_nxt;
      found_range_r <= found_range_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

endmodule

// File: rtl/core/ans_fifo.sv
// Short job queue between the front end and the back end.
// Depends on ans_pkg for the job struct.
module ans_fifo
  import ans_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_data
);

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);

  job_t              mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              push;
  logic              pop;

  assign push_ready = fill_r != FILL_W'(DEPTH);
  assign pop_valid  = fill_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + FILL_W'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/core/ans_back.sv
// Back end: per-point support radius from the count table, two partial
// products and a bit-serial square root, with the output register. Depends on ans_pkg.
module ans_back
  import ans_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      radius_given,
  input  logic      job_valid,
  output logic      job_ready,
  input  job_t      job_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int PP_W  = K_W + HALF_W;
  localparam int SUM_W = K_W + DIST_W;
  localparam int REM_W = ROOT_W + 3;

  back_state_t       state_r, state_nxt;
  job_t              job_r, job_nxt;
  logic [K_W-1:0]    k_r, k_nxt;
  logic [PP_W-1:0]   prod_hi_r, prod_hi_nxt;
  logic [PP_W-1:0]   prod_lo_r, prod_lo_nxt;
  logic [SQ_SRC_W-1:0] src_r, src_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]  range_r, range_nxt;
  logic [ROOT_W-1:0] support_r, support_nxt;
  logic [DIST_W-1:0] given_r, given_nxt;
  logic              overflow_r, overflow_nxt;
  logic [SUM_W-1:0]  prod_sum;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;

  assign prod_sum = {prod_hi_r, HALF_W'(0)} + SUM_W'(prod_lo_r);
  assign rem_sh   = {rem_r[ROOT_W:0], src_r[SQ_SRC_W-1 -: 2]};
  assign trial    = REM_W'({root_r, 2'b01});

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    k_nxt         = k_r;
    prod_hi_nxt   = prod_hi_r;
    prod_lo_nxt   = prod_lo_r;
    src_nxt       = src_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    range_nxt     = range_r;
    support_nxt   = support_r;
    given_nxt     = given_r;
    overflow_nxt  = overflow_r;
    job_ready     = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      BK_IDLE: begin
        if (job_valid) begin
          job_ready = 1'b1;
          job_nxt   = job_data;
          k_nxt     = K_TABLE[job_data.n];
          state_nxt = BK_MUL;
        end
      end
      BK_MUL: begin
        prod_hi_nxt = PP_W'(job_r.distance[DIST_W-1:HALF_W]) * PP_W'(k_r);
        prod_lo_nxt = PP_W'(job_r.distance[HALF_W-1:0]) * PP_W'(k_r);
        state_nxt   = BK_SUM;
      end
      BK_SUM: begin
        src_nxt   = SQ_SRC_W'(prod_sum[SUM_W-1:SCALE_SH]);
        rem_nxt   = '0;
        root_nxt  = '0;
        step_nxt  = '0;
        state_nxt = BK_ROOT;
      end
      BK_ROOT: begin
        src_nxt = {src_r[SQ_SRC_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_nxt  = rem_sh - trial;
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh;
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
        if (step_r == STEP_W'(ROOT_W - 1)) begin
          state_nxt = BK_OUT;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      BK_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          range_nxt     = job_r.range;
          support_nxt   = root_r;
          given_nxt     = job_r.given_radius;
          overflow_nxt  = job_r.overflow;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_data.range    = range_r;
  assign out_data.support  = DIST_W'(support_r);
  assign out_data.radius   = radius_given ? given_r : DIST_W'(support_r);
  assign out_data.overflow = overflow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    k_r        <= k_nxt;
    prod_hi_r  <= prod_hi_nxt;
    prod_lo_r  <= prod_lo_nxt;
    src_r      <= src_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    range_r    <= range_nxt;
    support_r  <= support_nxt;
    given_r    <= given_nxt;
    overflow_r <= overflow_nxt;
  end

endmodule

// File: rtl/core/adaptive_neighborhood_support.sv
// Top level of the adaptive neighborhood support block: configuration registers,
// front end, job queue and back end. Depends on ans_pkg, ans_front, ans_fifo, ans_back.
//
// Usage: the input channel carries one squared neighbor distance per transaction,
// nearest first, and the transaction with last set closes the point. Each closed
// point yields one result transaction with the range, the support radius, the point
// radius and the overflow flag. Configuration (density threshold, radius source) is
// written through cfg_we, cfg_index and cfg_wdata while the block is idle.
// Throughput: the front end takes one distance per cycle while the job queue has room.
// The back end handles one point at a time (count table lookup, two 16 x 27 partial
// products, a sum and 26 steps of the bit-serial square root, then the output load),
// so short points are paced by the back end once the two-entry queue fills.
// With no stall, the last distance passes the stage register, the queue and the back end.
// Reset clears the neighbor count, the range search, the queue and the output
// register, and loads the density threshold 0.02 with the support as radius.
// When the receiver stalls, the result holds in the output register, the back end
// waits with its next result, and the queue then fills and stalls the input.
module adaptive_neighborhood_support
  import ans_pkg::*;
#(
  parameter int NBR_CAPACITY = NBR_CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  cfg_index_t        cfg_index,
  input  logic [DENS_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data
);

  logic [DENS_W-1:0] density_r, density_nxt;
  logic              radius_given_r, radius_given_nxt;
  logic              f_job_valid;
  logic              f_job_ready;
  job_t              f_job_data;
  logic              b_job_valid;
  logic              b_job_ready;
  job_t              b_job_data;

  always_comb begin
    density_nxt      = density_r;
    radius_given_nxt = radius_given_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_DENSITY:      density_nxt      = cfg_wdata;
        CFG_RADIUS_GIVEN: radius_given_nxt = cfg_wdata[0];
        default:          density_nxt      = density_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      density_r      <= DENSITY_RST;
      radius_given_r <= 1'b0;
    end else begin
      density_r      <= density_nxt;
      radius_given_r <= radius_given_nxt;
    end
  end

  ans_front #(
    .NBR_CAPACITY(NBR_CAPACITY)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .density   (density_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (f_job_valid),
    .job_ready (f_job_ready),
    .job_data  (f_job_data)
  );

  ans_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_job_valid),
    .push_ready (f_job_ready),
    .push_data  (f_job_data),
    .pop_valid  (b_job_valid),
    .pop_ready  (b_job_ready),
    .pop_data   (b_job_data)
  );

  ans_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .radius_given (radius_given_r),
    .job_valid    (b_job_valid),
    .job_ready    (b_job_ready),
    .job_data     (b_job_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.range >= MIN_RANGE) &&
                  (out_data.range <= CNT_W'(NBR_CAPACITY)))
    else $error("Result range outside the neighbor capacity.");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.support[DIST_W-1:ROOT_W] == '0))
    else $error("Support radius wider than the square root result.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !radius_given_r) |-> (out_data.radius == out_data.support))
    else $error("Radius differs from support while support is selected.");

  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (f_job_valid && !f_job_ready))
    else $error("Input stalled without a full job queue.");

endmodule
